FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/pat_pkg.sv
`default_nettype none
package pat_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int PATH_BYTES  = 64;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    localparam int W_POS  = $clog2(PATH_BYTES + 1);
    localparam int W_ADDR = $clog2(PATH_BYTES);
    localparam int W_IDX  = 4;
    localparam int W_CNT  = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DENIED  = 2'd1;
    localparam logic [1:0] ST_NOPERM  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic              en;
        logic [W_ADDR-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic             en;
        logic [7:0]       data;
        logic [W_POS-1:0] pos;
    } t_cmp;

    typedef struct packed {
        logic              clr;
        logic              we_new;
        logic              we_perm;
        logic [W_IDX-1:0]  idx;
        logic [W_ADDR-1:0] len;
        logic [2:0]        perm;
        logic              eslash;
    } t_upd;

    typedef struct packed {
        logic             is_add;
        logic [W_POS-1:0] qlen;
    } t_scan_cfg;

    typedef struct packed {
        logic              vld;
        logic              found;
        logic [W_ADDR-1:0] top_len;
        logic [W_IDX-1:0]  idx;
        logic [2:0]        perm;
    } t_scan;

    typedef struct packed {
        logic [2:0]       perm;
        logic [W_IDX-1:0] idx;
        logic             matched;
        logic [1:0]       status;
    } t_res;
endpackage
`default_nettype wire

FILE: hdl/pat_cell.sv
`default_nettype none
module pat_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [pat_pkg::W_IDX-1:0]   i_index,
    input  wire  [pat_pkg::W_CNT-1:0]   i_count,
    input  wire  [pat_pkg::W_ADDR-1:0]  i_rd_addr,
    input  pat_pkg::t_wr                i_wr,
    input  pat_pkg::t_cmp               i_cmp,
    input  pat_pkg::t_upd               i_upd,
    input  pat_pkg::t_scan_cfg          i_cfg,
    input  pat_pkg::t_scan              i_scan,
    output pat_pkg::t_scan              o_scan
);
    import pat_pkg::*;

    logic [7:0]        r_mem [PATH_BYTES];
    logic [7:0]        r_rd;
    logic [W_ADDR-1:0] r_len;
    logic [2:0]        r_perm;
    logic              r_eslash;
    logic              r_alive;
    logic              r_slash;
    t_scan             r_scan;
    t_scan             n_scan;
    logic              w_valid;
    logic              w_sel;
    logic [W_POS-1:0]  w_len;
    logic              w_cand;

    assign w_valid = {{(W_CNT-W_IDX){1'b0}}, i_index} < i_count;
    assign w_sel   = {{(W_CNT-W_IDX){1'b0}}, i_index} == i_count;
    assign w_len   = {{(W_POS-W_ADDR){1'b0}}, r_len};

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_sel) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.we_new && i_upd.idx == i_index) begin
            r_len    <= i_upd.len;
            r_perm   <= i_upd.perm;
            r_eslash <= i_upd.eslash;
        end else if (i_upd.we_perm && i_upd.idx == i_index) begin
            r_perm <= i_upd.perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_upd.clr) begin
            r_alive <= 1'b1;
            r_slash <= 1'b0;
        end else if (i_cmp.en && w_valid) begin
            if (i_cmp.pos < w_len) begin
                if (r_rd != i_cmp.data) begin
                    r_alive <= 1'b0;
                end
            end else if (i_cmp.pos == w_len) begin
                r_slash <= (i_cmp.data == SLASH_CHAR);
            end
        end
    end

    always_comb begin
        n_scan = i_scan;
        w_cand = 1'b0;
        if (i_scan.vld && w_valid && r_alive) begin
            if (i_cfg.is_add) begin
                if (!i_scan.found && w_len == i_cfg.qlen) begin
                    n_scan.found = 1'b1;
                    n_scan.idx   = i_index;
                    n_scan.perm  = r_perm;
                end
            end else begin
                w_cand = (r_len != '0) && (w_len <= i_cfg.qlen)
                       && ((w_len == i_cfg.qlen) || r_slash || r_eslash);
                if (w_cand && r_len > i_scan.top_len) begin
                    n_scan.found   = 1'b1;
                    n_scan.top_len = r_len;
                    n_scan.idx     = i_index;
                    n_scan.perm    = r_perm;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;
endmodule
`default_nettype wire

FILE: hdl/path_prefix_access_table.sv
// channel | dir | handshake            | payload
// s_axis  | in  | s_axis_tvalid/tready | tdata: path_byte, perm_bits; tuser: command; tlast
// m_axis  | out | m_axis_tvalid/tready | tdata: status, matched, entry_index, entry_perms_out
// a path byte goes through an entry memory read, then a compare in every cell that holds an entry
// a byte after the terminating zero, or the zero itself, is accepted without a compare step
// a last beat starts a best-match pass along the cell chain, then the output load
// a lock beat skips compare and scan; a result waits in the output register as input continues
// the output load, with s_axis_tready low, stalls while the previous beat is still waiting
// i_rst_n clears table count, lock and stream state; entry contents stay undefined
`default_nettype none
module path_prefix_access_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // path_byte[7:0], perm_bits[10:8], zeros
    input  wire  [1:0]  s_axis_tuser,  // command[1:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[1:0], matched[2], entry_index[6:3],
                                       // entry_perms_out[9:7], zeros
);
    import pat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [W_POS-1:0] r_pos, n_pos;
    logic             r_ended, n_ended;
    logic [1:0]       r_cmd;
    logic [2:0]       r_perm;
    logic [7:0]       r_byte;
    logic [W_POS-1:0] r_cmp_pos;
    logic             r_last;
    logic             r_prev_slash;
    logic [W_CNT-1:0] r_count, n_count;
    logic             r_restrict, n_restrict;
    logic             r_sealed, n_sealed;
    t_res             r_res, n_res;
    t_res             r_out;
    logic             r_out_vld;
    logic             r_go;

    logic             w_acc;
    logic [7:0]       w_byte;
    logic             w_take;
    logic             w_done;
    t_wr              w_wr;
    t_cmp             w_cmp;
    t_upd             w_upd;
    t_scan_cfg        w_cfg;
    t_scan            w_scan [MAX_ENTRIES+1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_byte = s_axis_tdata[7:0];
    assign w_take = w_acc && !s_axis_tuser[1] && !r_ended && (w_byte != 8'd0);
    assign w_done = (r_state == S_SCAN) && w_scan[MAX_ENTRIES].vld;

    assign w_wr.en   = w_take && (r_pos < W_POS'(PATH_BYTES - 1));
    assign w_wr.addr = r_pos[W_ADDR-1:0];
    assign w_wr.data = w_byte;

    assign w_cmp.en   = (r_state == S_CMP);
    assign w_cmp.data = r_byte;
    assign w_cmp.pos  = r_cmp_pos;

    assign w_cfg.is_add = (r_cmd == CMD_ADD);
    assign w_cfg.qlen   = (w_cfg.is_add && r_pos > W_POS'(PATH_BYTES - 1))
                        ? W_POS'(PATH_BYTES - 1) : r_pos;

    assign w_scan[0] = '{vld: r_go, found: 1'b0, top_len: '0, idx: '0, perm: '0};

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        pat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (W_IDX'(g)),
            .i_count  (r_count),
            .i_rd_addr(r_pos[W_ADDR-1:0]),
            .i_wr     (w_wr),
            .i_cmp    (w_cmp),
            .i_upd    (w_upd),
            .i_cfg    (w_cfg),
            .i_scan   (w_scan[g]),
            .o_scan   (w_scan[g+1])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_ended    = r_ended;
        n_count    = r_count;
        n_restrict = r_restrict;
        n_sealed   = r_sealed;
        n_res      = r_res;
        w_upd      = '0;
        w_upd.len  = w_cfg.qlen[W_ADDR-1:0];
        w_upd.eslash = r_prev_slash;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser[1]) begin
                        n_restrict = 1'b1;
                        n_sealed   = 1'b1;
                        w_upd.clr  = 1'b1;
                        n_pos      = '0;
                        n_ended    = 1'b0;
                        n_res      = '{perm: '0, idx: '0, matched: 1'b0, status: ST_OK};
                        n_state    = S_OUT;
                    end else if (w_take) begin
                        if (r_pos < W_POS'(PATH_BYTES)) begin
                            n_pos = r_pos + W_POS'(1);
                        end
                        n_state = S_CMP;
                    end else begin
                        if (!r_ended) begin
                            n_ended = 1'b1;
                        end
                        if (s_axis_tlast) begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_CMP: begin
                n_state = r_last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (w_done) begin
                    w_upd.clr = 1'b1;
                    n_pos     = '0;
                    n_ended   = 1'b0;
                    n_state   = S_OUT;
                    n_res     = '0;
                    if (!w_cfg.is_add) begin
                        if (r_restrict && r_perm != 3'd0) begin
                            if (!w_scan[MAX_ENTRIES].found) begin
                                n_res.status = ST_DENIED;
                            end else begin
                                n_res.matched = 1'b1;
                                n_res.idx     = w_scan[MAX_ENTRIES].idx;
                                n_res.perm    = w_scan[MAX_ENTRIES].perm;
                                n_res.status  =
                                    ((r_perm & w_scan[MAX_ENTRIES].perm) == r_perm)
                                    ? ST_OK : ST_DENIED;
                            end
                        end
                    end else if (r_sealed) begin
                        n_res.status = ST_NOPERM;
                    end else if (w_cfg.qlen == '0) begin
                        n_res.status = ST_INVALID;
                    end else if (w_scan[MAX_ENTRIES].found) begin
                        n_res.matched = 1'b1;
                        n_res.idx     = w_scan[MAX_ENTRIES].idx;
                        if ((r_perm & ~w_scan[MAX_ENTRIES].perm) != 3'd0) begin
                            n_res.status = ST_NOPERM;
                            n_res.perm   = w_scan[MAX_ENTRIES].perm;
                        end else begin
                            n_res.perm    = r_perm & w_scan[MAX_ENTRIES].perm;
                            w_upd.we_perm = 1'b1;
                            w_upd.idx     = w_scan[MAX_ENTRIES].idx;
                            w_upd.perm    = r_perm & w_scan[MAX_ENTRIES].perm;
                            n_restrict    = 1'b1;
                        end
                    end else if (r_count >= W_CNT'(MAX_ENTRIES)) begin
                        n_res.status = ST_NOPERM;
                    end else begin
                        n_res.matched = 1'b1;
                        n_res.idx     = r_count[W_IDX-1:0];
                        n_res.perm    = r_perm;
                        w_upd.we_new  = 1'b1;
                        w_upd.idx     = r_count[W_IDX-1:0];
                        w_upd.perm    = r_perm;
                        n_count       = r_count + W_CNT'(1);
                        n_restrict    = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_ended    <= 1'b0;
            r_count    <= '0;
            r_restrict <= 1'b0;
            r_sealed   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_go       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_ended    <= n_ended;
            r_count    <= n_count;
            r_restrict <= n_restrict;
            r_sealed   <= n_sealed;
            r_go       <= (n_state == S_SCAN) && (r_state != S_SCAN);
            if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_acc) begin
            r_cmd     <= s_axis_tuser;
            r_perm    <= s_axis_tdata[10:8];
            r_byte    <= w_byte;
            r_cmp_pos <= r_pos;
            r_last    <= s_axis_tlast;
        end
        if (w_wr.en) begin
            r_prev_slash <= (w_byte == SLASH_CHAR);
        end
        if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out};
endmodule
`default_nettype wire

FILE: hdl/pat_chk.sv
`default_nettype none
`include "assert_macros.svh"
module pat_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        i_s_tready,
    input wire [1:0]  i_s_tuser,
    input wire        i_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] i_m_tdata
);
    `AST_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))
    `AST_NEXT(a_lock_busy, i_s_tvalid && i_s_tready && i_s_tuser[1], !i_s_tready)
    `AST_NOW(a_invalid_unmatched, i_m_tvalid && i_m_tdata[1:0] == 2'd3, !i_m_tdata[2])
    `AST_NOW(a_unmatched_zero, i_m_tvalid && !i_m_tdata[2], i_m_tdata[9:3] == 7'd0)
endmodule

bind path_prefix_access_table pat_chk u_pat_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
`default_nettype wire
